[sv/tdc_pkg.sv]
`default_nettype none
package tdc_pkg;

  localparam int MaxCalSamples = 255;
  localparam int CntW = 8;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
  } tdc_in_t;

  typedef struct packed {
    logic [2:0]         direction;
    logic signed [47:0] speed_sum;
    logic signed [15:0] corrected_x;
    logic signed [15:0] corrected_y;
    logic signed [15:0] corrected_z;
  } tdc_out_t;

  // Direction codes.
  localparam logic [2:0] DirStill = 3'd0;
  localparam logic [2:0] DirRight = 3'd1;
  localparam logic [2:0] DirLeft  = 3'd2;
  localparam logic [2:0] DirFwd   = 3'd3;
  localparam logic [2:0] DirBack  = 3'd4;

  // Register addresses (word index).
  localparam logic [1:0] RegCal    = 2'd0;
  localparam logic [1:0] RegGrav   = 2'd1;
  localparam logic [1:0] RegMargin = 2'd2;

  // What one axis lane reports to the merge stage.
  typedef struct packed {
    logic               pos;
    logic               neg;
    logic signed [47:0] acc;
  } tdc_lane_t;

endpackage
`default_nettype wire

[sv/tdc_divu.sv]
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module tdc_divu
  import tdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [39:0] dividend,
  input  wire logic [7:0]  divisor,
  output logic             done,
  output logic [39:0]      quotient
);
  logic [5:0]  cnt;
  logic        busy;
  logic [39:0] q;
  logic [8:0]  rem;
  logic [8:0]  trial;

  assign trial = {rem[7:0], q[39]};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd40;
        q    <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          q   <= {q[38:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[38:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[sv/tdc_isqrt.sv]
`default_nettype none
// Bit-pair integer square root, one result bit per cycle.
module tdc_isqrt
  import tdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [40:0] radicand,
  output logic             done,
  output logic [20:0]      root
);
  logic        busy;
  logic [4:0]  cnt;
  logic [41:0] x;
  logic [22:0] rem;
  logic [20:0] r;
  logic [22:0] trial;
  logic [22:0] sub;

  assign trial = {rem[20:0], x[41:40]};
  assign sub   = {r, 2'b01};
  assign root  = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd21;
        x    <= {1'b0, radicand};
        rem  <= '0;
        r    <= '0;
      end else if (busy) begin
        x <= {x[39:0], 2'b00};
        if (trial >= sub) begin
          rem <= trial - sub;
          r   <= {r[19:0], 1'b1};
        end else begin
          rem <= trial;
          r   <= {r[19:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[sv/tdc_lane.sv]
`default_nettype none
// One horizontal axis: offset correction, trapezoid speed and threshold test.
module tdc_lane
  import tdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic signed [15:0] sample,
  input  wire logic signed [15:0] offset,
  input  wire logic [19:0]        thr,
  output logic signed [15:0]      corr,
  output tdc_lane_t               info
);
  logic signed [15:0] prev;
  logic signed [47:0] acc;
  logic signed [48:0] sum;
  logic signed [47:0] acc_next;
  localparam logic signed [48:0] AccMax = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] AccMin = -49'sh0_8000_0000_0000;

  assign corr = sample - offset;
  assign sum  = 49'(acc) + 49'(prev) + 49'(corr);

  always_comb begin
    if (sum > AccMax) acc_next = AccMax[47:0];
    else if (sum < AccMin) acc_next = AccMin[47:0];
    else acc_next = sum[47:0];
  end

  assign info.acc = acc_next;
  assign info.pos = 21'(corr) > $signed({1'b0, thr});
  assign info.neg = 21'(corr) < -$signed({1'b0, thr});

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
      acc  <= '0;
    end else if (step) begin
      prev <= corr;
      acc  <= acc_next;
    end
  end
endmodule
`default_nettype wire

[sv/tilt_direction_classifier_top.sv]
`default_nettype none
// Tilt direction classifier. After reset the first cal_samples items (1 to 255,
// 0 acting as 1) only calibrate and give no result; the last of them starts a
// finishing pass (five divides for the two mean squares and the three means,
// then two square roots, on one shared divider and one root unit) with stall
// high. Then each item gives one result, held in an output register; items
// are taken back to back unless out_stall holds it or the thresholds refresh.
// The x and y lanes run side by side and a merge stage picks the direction.
// Stall also rises for one cycle after any register write while the thresholds
// refresh. Registers must be written only while idle; the block does not enforce it.
module tilt_direction_classifier_top
  import tdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire tdc_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output tdc_out_t        out_data,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  typedef enum logic [3:0] {
    S_CAL, S_MY, S_DX, S_DY, S_DZ, S_SX, S_SY, S_RUN
  } state_t;

  state_t state;
  logic [7:0]  cal_samples;
  logic [14:0] gravity_counts;
  logic [7:0]  margin_tenths;
  logic [7:0]  cal_count;
  logic signed [23:0] sum_x, sum_y, sum_z;
  logic [39:0] sumsq_x, sumsq_y;
  logic signed [15:0] offset_x, offset_y, offset_z;
  logic [14:0] noise_x, noise_y;
  logic [19:0] thr_x, thr_y;
  logic [14:0] grav_cal;
  logic        cfg_wr;
  logic        thr_ready;
  logic        msq_phase;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    case (paddr[3:2])
      RegCal:    prdata = {24'd0, cal_samples};
      RegGrav:   prdata = {17'd0, gravity_counts};
      RegMargin: prdata = {24'd0, margin_tenths};
      default:   prdata = '0;
    endcase
  end

  // Handshake.
  logic take;
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == S_CAL && !msq_phase) ? 1'b0 :
                    (state == S_RUN) ? (!out_free || !thr_ready) : 1'b1;
  assign take = in_valid && !in_stall;

  // Shared divider and root.
  logic        div_start, div_done;
  logic [39:0] div_a, div_q;
  logic        sq_start, sq_done;
  logic [40:0] sq_a;
  logic [20:0] sq_r;
  logic        sign_q;
  logic [23:0] mag;

  tdc_divu u_div (.clk, .rst, .start(div_start), .dividend(div_a), .divisor(cal_count),
                  .done(div_done), .quotient(div_q));
  tdc_isqrt u_sq (.clk, .rst, .start(sq_start), .radicand(sq_a), .done(sq_done),
                  .root(sq_r));

  // Truncated signed mean of the selected sum.
  logic signed [23:0] sel_sum;
  always_comb begin
    case (state)
      S_DY:    sel_sum = sum_y;
      S_DZ:    sel_sum = sum_z;
      default: sel_sum = sum_x;
    endcase
  end
  assign mag = sel_sum[23] ? -sel_sum : sel_sum;
  logic signed [23:0] mean;
  assign mean = sign_q ? -div_q[23:0] : div_q[23:0];

  // Mean square, then variance.
  logic [39:0] msq_x, msq_y;
  logic signed [41:0] var_v;
  logic signed [15:0] sel_off;
  logic [39:0] sel_msq;
  assign sel_off = (state == S_SY) ? offset_y : offset_x;
  assign sel_msq = (state == S_SY) ? msq_y : msq_x;
  assign var_v = $signed({2'b0, sel_msq}) - 42'(sel_off * sel_off);
  assign sq_a = var_v[41] ? '0 : var_v[40:0];

  // Thresholds: noise * margin / 10 by a reciprocal exact for 23-bit products.
  function automatic logic [19:0] div10(input logic [22:0] p);
    logic [46:0] m;
    m = 47'(p) * 47'd13421773;
    div10 = m[46:27];
  endfunction
  logic [22:0] px_q, py_q;
  always_ff @(posedge clk) begin
    px_q  <= noise_x * margin_tenths;
    py_q  <= noise_y * margin_tenths;
  end
  assign thr_x = div10(px_q);
  assign thr_y = div10(py_q);

  // The products above are registered from the noise levels and the margin.
  always_ff @(posedge clk) begin
    if (rst) thr_ready <= 1'b0;
    else thr_ready <= (state == S_RUN) && !cfg_wr;
  end

  logic pend;
  logic [7:0] target;
  always_comb begin
    target = (cal_samples == 8'd0) ? 8'd1 : cal_samples;
    div_a  = {16'd0, mag};
    if (state == S_CAL) div_a = sumsq_x;
    else if (state == S_MY) div_a = sumsq_y;
  end
  assign div_start = pend;
  assign sq_start  = pend && (state == S_SX || state == S_SY);

  // Lanes and merge.
  tdc_lane_t lx, ly;
  logic signed [15:0] cx, cy, cz;
  logic step;
  assign step = take && state == S_RUN;
  assign cz = in_data.sample_z - offset_z;
  tdc_lane u_lx (.clk, .rst, .step, .sample(in_data.sample_x), .offset(offset_x),
                 .thr(thr_x), .corr(cx), .info(lx));
  tdc_lane u_ly (.clk, .rst, .step, .sample(in_data.sample_y), .offset(offset_y),
                 .thr(thr_y), .corr(cy), .info(ly));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_free) out_valid <= 1'b0;
      if (step) begin
        out_valid <= 1'b1;
        out_data.corrected_x <= cx;
        out_data.corrected_y <= cy;
        out_data.corrected_z <= cz;
        if (lx.pos) begin
          out_data.direction <= DirRight; out_data.speed_sum <= lx.acc;
        end else if (lx.neg) begin
          out_data.direction <= DirLeft;  out_data.speed_sum <= lx.acc;
        end else if (ly.pos) begin
          out_data.direction <= DirFwd;   out_data.speed_sum <= ly.acc;
        end else if (ly.neg) begin
          out_data.direction <= DirBack;  out_data.speed_sum <= ly.acc;
        end else begin
          out_data.direction <= DirStill; out_data.speed_sum <= '0;
        end
      end
    end
  end

  // Calibration sequencer. The mean squares of x and y take the divider first,
  // then the three means, then the two roots.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CAL; cal_count <= '0; pend <= 1'b0; msq_phase <= 1'b0;
      sum_x <= '0; sum_y <= '0; sum_z <= '0; sumsq_x <= '0; sumsq_y <= '0;
      offset_x <= '0; offset_y <= '0; offset_z <= '0; noise_x <= '0; noise_y <= '0;
      cal_samples <= 8'd200; gravity_counts <= 15'd16384; margin_tenths <= 8'd11;
      sign_q <= 1'b0; msq_x <= '0; msq_y <= '0; grav_cal <= '0;
    end else begin
      pend <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          RegCal:    cal_samples <= pwdata[7:0];
          RegGrav:   gravity_counts <= pwdata[14:0];
          RegMargin: margin_tenths <= pwdata[7:0];
          default:   ;
        endcase
      end
      case (state)
        S_CAL: begin
          if (take && !msq_phase) begin
            sum_x   <= sum_x + 24'(in_data.sample_x);
            sum_y   <= sum_y + 24'(in_data.sample_y);
            sum_z   <= sum_z + 24'(in_data.sample_z);
            sumsq_x <= sumsq_x + 40'(in_data.sample_x * in_data.sample_x);
            sumsq_y <= sumsq_y + 40'(in_data.sample_y * in_data.sample_y);
            cal_count <= cal_count + 8'd1;
            if (cal_count + 8'd1 >= target) begin
              msq_phase <= 1'b1; pend <= 1'b1; grav_cal <= gravity_counts;
            end
          end
          if (msq_phase && div_done) begin
            msq_x <= div_q;
            state <= S_MY; pend <= 1'b1;
          end
        end
        S_MY: if (div_done) begin
          msq_y <= div_q;
          state <= S_DX; pend <= 1'b1; sign_q <= sum_x[23];
        end
        S_DX: if (div_done) begin
          offset_x <= mean[15:0]; state <= S_DY; pend <= 1'b1; sign_q <= sum_y[23];
        end
        S_DY: if (div_done) begin
          offset_y <= mean[15:0]; state <= S_DZ; pend <= 1'b1; sign_q <= sum_z[23];
        end
        S_DZ: if (div_done) begin
          offset_z <= 16'(mean - 24'(grav_cal));
          state <= S_SX; pend <= 1'b1;
        end
        S_SX: if (sq_done) begin
          noise_x <= (sq_r > 21'd32767) ? 15'h7FFF : sq_r[14:0];
          state <= S_SY; pend <= 1'b1;
        end
        S_SY: if (sq_done) begin
          noise_y <= (sq_r > 21'd32767) ? 15'h7FFF : sq_r[14:0];
          state <= S_RUN;
        end
        S_RUN: ;
        default: state <= S_CAL;
      endcase
    end
  end

  // Checks.
  property p_no_out_in_cal;
    @(posedge clk) disable iff (rst) (state != S_RUN) |=> !$rose(out_valid);
  endproperty
  a1: assert property (p_no_out_in_cal) else $error("result during calibration");
  a2: assert property (@(posedge clk) disable iff (rst)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
  a3: assert property (@(posedge clk) disable iff (rst)
        cal_count <= 8'd255) else $error("count overrun");
endmodule
`default_nettype wire
